@@ design/des_key_schedule_assert.svh @@
// assertion macros for the des key schedule block
// used by des_key_schedule.sv; needs a clock and an active high reset in scope
`ifndef DES_KEY_SCHEDULE_ASSERT_SVH
`define DES_KEY_SCHEDULE_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define KS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("des key schedule check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define KS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("des key schedule check failed");

`endif

@@ design/des_ks_pkg.sv @@
// shared types, tables and functions of the des key schedule
// no dependencies; used by every other file of the block except the assertion header
`timescale 1ns / 1ps

package des_ks_pkg;

   localparam int KsKeyBits     = 64;
   localparam int KsHalfBits    = 28;
   localparam int KsPc1Bits     = 56;
   localparam int KsSubkeyBits  = 48;
   localparam int KsChunkBits   = 6;
   localparam int KsRounds      = 16;
   localparam int KsWordBits    = 32;
   localparam int KsRoundBits   = 4;
   localparam int KsShiftBits   = 5;
   localparam int KsQueueDepth  = 2;

   localparam logic [KsRoundBits-1:0] KsLastRound = 4'd15;

   // pc-1 selection table, des key bit numbers counted from the msb
   localparam logic [6:0] Pc1Table [KsPc1Bits] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
      7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   // pc-2 selection table over the bits of the rotated halves
   localparam logic [5:0] Pc2Table [KsSubkeyBits] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   // cumulative left rotation of each half, first round to last
   localparam logic [KsShiftBits-1:0] CumShiftTable [KsRounds] = '{
      5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
      5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
   };

   // one queued key: both halves after pc-1 and the order flag
   typedef struct packed {
      logic [0:KsHalfBits-1] c;
      logic [0:KsHalfBits-1] d;
      logic                  decrypt;
   } ks_entry_type;

   // the two packed output words of one subkey
   typedef struct packed {
      logic [KsWordBits-1:0] even_word;
      logic [KsWordBits-1:0] odd_word;
   } ks_words_type;

   // pc-1: bit j of the result is des key bit pc1[j]
   function automatic logic [0:KsPc1Bits-1] pc1(input logic [KsKeyBits-1:0] key);
      logic [0:KsPc1Bits-1] sel;
      for (int j = 0; j < KsPc1Bits; j++) begin
         sel[j] = key[6'(7'd64 - Pc1Table[j])];
      end
      return sel;
   endfunction

   // left rotation of a half, by up to its full length
   function automatic logic [0:KsHalfBits-1] rotl28(input logic [0:KsHalfBits-1] v,
                                                   input logic [KsShiftBits-1:0] sh);
      logic [0:2*KsHalfBits-1] vv;
      vv = {v, v};
      return vv[sh +: KsHalfBits];
   endfunction

   // pc-2 and packing of the eight 6-bit chunks into the two words
   function automatic ks_words_type pc2_pack(input logic [0:KsPc1Bits-1] cd);
      ks_words_type w;
      int           j;
      int           pos;
      w = '0;
      for (int b = 0; b < 4; b++) begin
         for (int k = 0; k < KsChunkBits; k++) begin
            pos = 29 - 8 * b - k;
            j = KsChunkBits * (2 * b) + k;
            w.even_word[pos] = cd[6'(Pc2Table[j] - 6'd1)];
            j = KsChunkBits * (2 * b + 1) + k;
            w.odd_word[pos] = cd[6'(Pc2Table[j] - 6'd1)];
         end
      end
      return w;
   endfunction

endpackage

@@ design/des_ks_if.sv @@
// channel interfaces of the des key schedule: key requests and subkey responses
// depends on des_ks_pkg for the field widths
`timescale 1ns / 1ps

interface des_ks_req_if import des_ks_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KsKeyBits-1:0] key;
   logic                 func;

   modport source (output valid, key, func, input ready);
   modport sink   (input valid, key, func, output ready);
endinterface

interface des_ks_rsp_if import des_ks_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KsRoundBits-1:0] round;
   logic [KsWordBits-1:0]  even_word;
   logic [KsWordBits-1:0]  odd_word;
   logic                   last;

   modport source (output valid, round, even_word, odd_word, last, input ready);
   modport sink   (input valid, round, even_word, odd_word, last, output ready);
endinterface

@@ design/des_ks_front.sv @@
// front end: takes key requests, applies pc-1 and holds the entry for the queue
// depends on des_ks_pkg and des_ks_req_if
`timescale 1ns / 1ps

module des_ks_front import des_ks_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   des_ks_req_if.sink    req,
   output logic          push_valid,
   output ks_entry_type  push_data,
   input  logic          push_ready
);

   logic                 valid_ff, valid_in;
   ks_entry_type         entry_ff, entry_in;
   logic [0:KsPc1Bits-1] sel;
   logic                 take;

   // stage is free when empty or when its entry moves on this cycle
   assign req.ready = !valid_ff || push_ready;
   assign take      = req.valid && req.ready;

   // pc-1 split into the two halves
   always_comb begin
      sel              = pc1(req.key);
      entry_in.c       = sel[0:KsHalfBits-1];
      entry_in.d       = sel[KsHalfBits:KsPc1Bits-1];
      entry_in.decrypt = req.func;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_data  = entry_ff;

endmodule

@@ design/des_ks_queue.sv @@
// short queue of pc-1 entries between the front and back ends
// depends on des_ks_pkg
`timescale 1ns / 1ps

module des_ks_queue import des_ks_pkg::*; #(
   parameter int DEPTH = KsQueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  ks_entry_type push_data,
   output logic         push_ready,
   output logic         pop_valid,
   output ks_entry_type pop_data,
   input  logic         pop_ready
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   ks_entry_type    entries [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/des_ks_back.sv @@
// back end: walks the sixteen rounds of one queued entry, one subkey per cycle while rsp is ready
// depends on des_ks_pkg and des_ks_rsp_if
`timescale 1ns / 1ps

module des_ks_back import des_ks_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   input  ks_entry_type  pop_data,
   output logic          pop_ready,
   des_ks_rsp_if.source  rsp
);

   logic                   active_ff, active_in;
   logic [KsRoundBits-1:0] cnt_ff, cnt_in;
   ks_entry_type           cd_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KsRoundBits-1:0] round_ff;
   logic                   last_ff;
   ks_words_type           words_ff, words_in;
   logic                   out_free, step, done, load;
   logic [KsRoundBits-1:0] shift_idx;
   logic [KsShiftBits-1:0] shift;
   logic [0:KsPc1Bits-1]   rot;

   // while a key is loaded, a subkey is produced whenever the output register can take it
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign step      = active_ff && out_free;
   assign done      = step && (cnt_ff == KsLastRound);
   assign pop_ready = !active_ff || done;
   assign load      = pop_valid && pop_ready;

   // decryption walks the shift table backward
   always_comb begin
      shift_idx = cd_ff.decrypt ? ~cnt_ff : cnt_ff;
      shift     = CumShiftTable[shift_idx];
      rot       = {rotl28(cd_ff.c, shift), rotl28(cd_ff.d, shift)};
      words_in  = pc2_pack(rot);
   end

   // round sequencing
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (load) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (done) begin
         active_in = 1'b0;
      end else if (step) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working halves of the current key
   always_ff @(posedge clock) begin
      if (load) begin
         cd_ff <= pop_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (step) begin
         round_ff <= cnt_ff;
         last_ff  <= (cnt_ff == KsLastRound);
         words_ff <= words_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.round     = round_ff;
   assign rsp.even_word = words_ff.even_word;
   assign rsp.odd_word  = words_ff.odd_word;
   assign rsp.last      = last_ff;

endmodule

@@ design/des_key_schedule.sv @@
// top level of the des key schedule: front end, entry queue and round engine
// depends on des_ks_pkg, des_ks_if, des_ks_front, des_ks_queue, des_ks_back
`timescale 1ns / 1ps

// Each key transferred on req yields sixteen subkey transfers on rsp, rounds
// in encryption order, or in reverse order when func is set, the sixteenth marked by
// last. The round engine turns out one subkey per cycle from its round counter
// while rsp is ready, and loads the next queued key as it finishes a key. After
// the key transfer, the first subkey passes the pc-1 register, the queue, the
// working register and the output register. Keys keep being taken while the
// engine works, until the front register and the queue (QUEUE_DEPTH entries)
// are full, and rsp may stall at any time without losing data.
module des_key_schedule import des_ks_pkg::*; #(
   parameter int QUEUE_DEPTH = KsQueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   des_ks_req_if.sink   req,
   des_ks_rsp_if.source rsp
);

`include "des_key_schedule_assert.svh"

   logic         push_valid, push_ready;
   ks_entry_type push_data;
   logic         pop_valid, pop_ready;
   ks_entry_type pop_data;

   des_ks_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   des_ks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   des_ks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

   // last marks exactly the final round index
   `KS_ASSERT_IMPLY(a_last_round, clock, reset, rsp.valid,
                    rsp.last == (rsp.round == KsLastRound))
   // within a key, rounds follow each other without gaps
   `KS_ASSERT_NEXT(a_round_seq, clock, reset, rsp.valid && rsp.ready && !rsp.last,
                   rsp.valid && (rsp.round == $past(rsp.round) + 4'd1))
   // a queued entry is only taken when the engine is free or finishing
   `KS_ASSERT_IMPLY(a_pop_gap, clock, reset, pop_valid && pop_ready && rsp.valid && !rsp.ready,
                    rsp.last)

endmodule
